// ----- hw/rtl/bahp_pkg.sv -----
`default_nettype none
package bahp_pkg;

  typedef enum logic [1:0] {
    PH_SCHEME,
    PH_BASIC,
    PH_OTHER,
    PH_REJECT
  } phase_t;

  typedef enum logic [2:0] {
    ST_ACCEPT,
    ST_DECODE,
    ST_TAIL,
    ST_SCHEME_OUT,
    ST_USER_OUT,
    ST_STATUS_OUT
  } state_t;

  localparam logic [1:0] KIND_SCHEME = 2'd0;
  localparam logic [1:0] KIND_USER   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] STS_EMPTY      = 3'd0;
  localparam logic [2:0] STS_REJECTED   = 3'd1;
  localparam logic [2:0] STS_SCHEME     = 3'd2;
  localparam logic [2:0] STS_NO_COLON   = 3'd3;
  localparam logic [2:0] STS_USER       = 3'd4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_9 = 8'h39;
  localparam logic [7:0] CASE_GAP = 8'd32;

  localparam int BASIC_LEN = 5;

  typedef struct packed {
    logic accept;
    logic decode_step;
    logic load_tail;
    logic clr_idx;
    logic issue_scheme;
    logic issue_user;
    logic issue_status;
  } cmd_t;

  typedef struct packed {
    logic quad_now;
    logic dq_last;
    logic tail_avail;
    logic scheme_done;
    logic user_done;
    logic stage_free;
  } stat_t;

  // bit 6 flags a base64 alphabet byte, bits 5:0 hold its value
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    logic       ok;
    d  = 8'd0;
    ok = 1'b1;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = c - CH_UP_A;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = c - CH_LO_A + 8'd26;
    end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
      d = c - CH_DIG_0 + 8'd52;
    end else if (c == CH_PLUS) begin
      d = 8'd62;
    end else if (c == CH_SLASH) begin
      d = 8'd63;
    end else begin
      ok = 1'b0;
    end
    return {ok, d[5:0]};
  endfunction

  function automatic logic [7:0] basic_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h62;
      3'd1:    ch = 8'h61;
      3'd2:    ch = 8'h73;
      3'd3:    ch = 8'h69;
      3'd4:    ch = 8'h63;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/bahp_ifs.sv -----
`default_nettype none
interface bahp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       is_last;

  modport source(output valid, data_byte, byte_present, is_last, input ready);
  modport sink(input valid, data_byte, byte_present, is_last, output ready);
endinterface

interface bahp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last_of_run;

  modport source(output valid, kind, out_byte, status, last_of_run, input ready);
  modport sink(input valid, kind, out_byte, status, last_of_run, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bahp_ctrl.sv -----
`default_nettype none
module bahp_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  input  wire            in_is_last,
  output logic           in_ready,
  input  bahp_pkg::stat_t stat,
  output bahp_pkg::cmd_t  cmd
);
  import bahp_pkg::*;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   tail_done_r, tail_done_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCEPT;
      last_r      <= 1'b0;
      tail_done_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      tail_done_r <= tail_done_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    tail_done_nxt = tail_done_r;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_ACCEPT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept    = 1'b1;
          last_nxt      = in_is_last;
          tail_done_nxt = 1'b0;
          if (stat.quad_now) begin
            state_nxt = ST_DECODE;
          end else if (in_is_last) begin
            state_nxt = ST_TAIL;
          end
        end
      end
      ST_DECODE: begin
        cmd.decode_step = 1'b1;
        if (stat.dq_last) begin
          if (!last_r) begin
            state_nxt = ST_ACCEPT;
          end else if (!tail_done_r) begin
            state_nxt = ST_TAIL;
          end else begin
            state_nxt = ST_SCHEME_OUT;
          end
        end
      end
      ST_TAIL: begin
        // leftover two or three sextets still give bytes
        cmd.load_tail = 1'b1;
        tail_done_nxt = 1'b1;
        if (stat.tail_avail) begin
          state_nxt = ST_DECODE;
        end else begin
          state_nxt = ST_SCHEME_OUT;
        end
      end
      ST_SCHEME_OUT: begin
        if (stat.scheme_done) begin
          cmd.clr_idx = 1'b1;
          state_nxt   = ST_USER_OUT;
        end else if (stat.stage_free) begin
          cmd.issue_scheme = 1'b1;
        end
      end
      ST_USER_OUT: begin
        if (stat.user_done) begin
          state_nxt = ST_STATUS_OUT;
        end else if (stat.stage_free) begin
          cmd.issue_user = 1'b1;
        end
      end
      ST_STATUS_OUT: begin
        if (stat.stage_free) begin
          cmd.issue_status = 1'b1;
          last_nxt         = 1'b0;
          state_nxt        = ST_ACCEPT;
        end
      end
      default: begin
        state_nxt = ST_ACCEPT;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bahp_dp.sv -----
`default_nettype none
module bahp_dp #(
  parameter int SCHEME_MAX   = 16,
  parameter int USER_MAX     = 32,
  parameter int DECODE_EXTRA = 256
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire       [7:0] in_data_byte,
  input  wire             in_byte_present,
  input  bahp_pkg::cmd_t  cmd,
  output bahp_pkg::stat_t stat,
  bahp_out_if.source      out_chan
);
  import bahp_pkg::*;

  localparam int SC_W    = $clog2(SCHEME_MAX);
  localparam int UC_W    = $clog2(USER_MAX);
  localparam int IDX_W   = (SC_W > UC_W) ? SC_W : UC_W;
  localparam int DEC_LIM = USER_MAX + DECODE_EXTRA - 1;
  localparam int DC_W    = $clog2(DEC_LIM + 1);

  // run state
  phase_t            phase_r, phase_nxt;
  logic [SC_W-1:0]   scheme_cnt_r, scheme_cnt_nxt;
  logic              basic_r, basic_nxt;
  logic [17:0]       hold_r, hold_nxt;
  logic [1:0]        sext_cnt_r, sext_cnt_nxt;
  logic [DC_W-1:0]   dec_cnt_r, dec_cnt_nxt;
  logic [UC_W-1:0]   user_cnt_r, user_cnt_nxt;
  logic              colon_r, colon_nxt;
  logic              search_end_r, search_end_nxt;
  logic              pad_r, pad_nxt;
  logic              hdr_end_r, hdr_end_nxt;

  // decoded byte queue
  logic [23:0]       dq_r, dq_nxt;
  logic [1:0]        dq_cnt_r, dq_cnt_nxt;

  // emission
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [1:0]        stage_kind_r;
  logic [2:0]        stage_sts_r;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_kind_r;
  logic [7:0]        out_byte_r;
  logic [2:0]        out_sts_r;
  logic              out_last_r;

  logic [7:0]        scheme_mem [SCHEME_MAX];
  logic [7:0]        user_mem [USER_MAX];
  logic [7:0]        sch_rdata_r;
  logic [7:0]        usr_rdata_r;

  logic              sch_we;
  logic              usr_we;
  logic [7:0]        lc;
  logic [6:0]        sx;
  logic [7:0]        dbyte;
  logic [2:0]        sts_code;
  logic              move;
  logic [7:0]        stage_byte;
  logic              quad_now;

  always_comb begin
    if (phase_r == PH_REJECT) begin
      sts_code = STS_REJECTED;
    end else if (phase_r == PH_SCHEME && scheme_cnt_r == '0) begin
      sts_code = STS_EMPTY;
    end else if (phase_r == PH_BASIC) begin
      sts_code = colon_r ? STS_USER : STS_NO_COLON;
    end else begin
      sts_code = STS_SCHEME;
    end
  end

  assign move = pend_r && (!out_valid_r || out_chan.ready);

  always_comb begin
    sx    = sextet_of(in_data_byte);
    lc    = (in_data_byte >= CH_UP_A && in_data_byte <= CH_UP_Z) ?
            in_data_byte + CASE_GAP : in_data_byte;
    dbyte = dq_r[23:16];

    phase_nxt      = phase_r;
    scheme_cnt_nxt = scheme_cnt_r;
    basic_nxt      = basic_r;
    hold_nxt       = hold_r;
    sext_cnt_nxt   = sext_cnt_r;
    dec_cnt_nxt    = dec_cnt_r;
    user_cnt_nxt   = user_cnt_r;
    colon_nxt      = colon_r;
    search_end_nxt = search_end_r;
    pad_nxt        = pad_r;
    hdr_end_nxt    = hdr_end_r;
    dq_nxt         = dq_r;
    dq_cnt_nxt     = dq_cnt_r;
    sch_we         = 1'b0;
    usr_we         = 1'b0;
    quad_now       = 1'b0;

    if (cmd.accept && in_byte_present && !hdr_end_r) begin
      if (in_data_byte == 8'd0) begin
        hdr_end_nxt = 1'b1;
      end else if (phase_r == PH_SCHEME) begin
        if (in_data_byte == CH_SPACE) begin
          if (scheme_cnt_r == '0) begin
            phase_nxt = PH_REJECT;
          end else if (scheme_cnt_r == SC_W'(BASIC_LEN) && basic_r) begin
            phase_nxt = PH_BASIC;
          end else begin
            phase_nxt = PH_OTHER;
          end
        end else if (scheme_cnt_r >= SC_W'(SCHEME_MAX - 1)) begin
          phase_nxt = PH_REJECT;
        end else begin
          if (scheme_cnt_r < SC_W'(BASIC_LEN)) begin
            if (lc != basic_char(scheme_cnt_r[2:0])) begin
              basic_nxt = 1'b0;
            end
          end else begin
            basic_nxt = 1'b0;
          end
          sch_we         = 1'b1;
          scheme_cnt_nxt = scheme_cnt_r + 1'b1;
        end
      end else if (phase_r == PH_BASIC && !pad_r) begin
        if (in_data_byte == CH_PAD) begin
          pad_nxt = 1'b1;
        end else if (sx[6]) begin
          if (sext_cnt_r == 2'd3) begin
            quad_now      = 1'b1;
            dq_nxt        = {hold_r, sx[5:0]};
            dq_cnt_nxt    = 2'd3;
            hold_nxt      = '0;
            sext_cnt_nxt  = 2'd0;
          end else begin
            hold_nxt     = {hold_r[11:0], sx[5:0]};
            sext_cnt_nxt = sext_cnt_r + 2'd1;
          end
        end
      end
    end

    if (cmd.load_tail && phase_r == PH_BASIC) begin
      if (sext_cnt_r == 2'd2) begin
        dq_nxt     = {hold_r[11:4], 16'd0};
        dq_cnt_nxt = 2'd1;
      end else if (sext_cnt_r == 2'd3) begin
        dq_nxt     = {hold_r[17:10], hold_r[9:2], 8'd0};
        dq_cnt_nxt = 2'd2;
      end
    end

    if (cmd.decode_step) begin
      dq_nxt     = {dq_r[15:0], 8'd0};
      dq_cnt_nxt = dq_cnt_r - 2'd1;
      if (dec_cnt_r < DC_W'(DEC_LIM)) begin
        dec_cnt_nxt = dec_cnt_r + 1'b1;
        if (!search_end_r && !colon_r) begin
          if (dbyte == CH_COLON) begin
            colon_nxt = 1'b1;
          end else if (dbyte == 8'd0) begin
            search_end_nxt = 1'b1;
          end else if (user_cnt_r < UC_W'(USER_MAX - 1)) begin
            usr_we       = 1'b1;
            user_cnt_nxt = user_cnt_r + 1'b1;
          end
        end
      end
    end

    if (cmd.issue_status) begin
      phase_nxt      = PH_SCHEME;
      scheme_cnt_nxt = '0;
      basic_nxt      = 1'b1;
      hold_nxt       = '0;
      sext_cnt_nxt   = 2'd0;
      dec_cnt_nxt    = '0;
      user_cnt_nxt   = '0;
      colon_nxt      = 1'b0;
      search_end_nxt = 1'b0;
      pad_nxt        = 1'b0;
      hdr_end_nxt    = 1'b0;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.clr_idx || cmd.issue_status) begin
      idx_nxt = '0;
    end else if (cmd.issue_scheme || cmd.issue_user) begin
      idx_nxt = idx_r + 1'b1;
    end

    pend_nxt = pend_r;
    if (cmd.issue_scheme || cmd.issue_user || cmd.issue_status) begin
      pend_nxt = 1'b1;
    end else if (move) begin
      pend_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (stage_kind_r)
      KIND_SCHEME: stage_byte = sch_rdata_r;
      KIND_USER:   stage_byte = usr_rdata_r;
      default:     stage_byte = 8'd0;
    endcase

    stat.quad_now    = quad_now;
    stat.dq_last     = (dq_cnt_r == 2'd1);
    stat.tail_avail  = (phase_r == PH_BASIC) && (sext_cnt_r >= 2'd2);
    stat.scheme_done = (idx_r == IDX_W'(scheme_cnt_r)) || (sts_code < STS_SCHEME);
    stat.user_done   = (idx_r == IDX_W'(user_cnt_r)) || (sts_code != STS_USER);
    stat.stage_free  = !pend_r || move;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SCHEME;
      scheme_cnt_r <= '0;
      basic_r      <= 1'b1;
      hold_r       <= '0;
      sext_cnt_r   <= 2'd0;
      dec_cnt_r    <= '0;
      user_cnt_r   <= '0;
      colon_r      <= 1'b0;
      search_end_r <= 1'b0;
      pad_r        <= 1'b0;
      hdr_end_r    <= 1'b0;
      dq_cnt_r     <= 2'd0;
      idx_r        <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      scheme_cnt_r <= scheme_cnt_nxt;
      basic_r      <= basic_nxt;
      hold_r       <= hold_nxt;
      sext_cnt_r   <= sext_cnt_nxt;
      dec_cnt_r    <= dec_cnt_nxt;
      user_cnt_r   <= user_cnt_nxt;
      colon_r      <= colon_nxt;
      search_end_r <= search_end_nxt;
      pad_r        <= pad_nxt;
      hdr_end_r    <= hdr_end_nxt;
      dq_cnt_r     <= dq_cnt_nxt;
      idx_r        <= idx_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r <= dq_nxt;
    if (sch_we) begin
      scheme_mem[scheme_cnt_r] <= in_data_byte;
    end
    if (usr_we) begin
      user_mem[user_cnt_r] <= dbyte;
    end
    if (cmd.issue_scheme) begin
      sch_rdata_r <= scheme_mem[idx_r[SC_W-1:0]];
    end
    if (cmd.issue_user) begin
      usr_rdata_r <= user_mem[idx_r[UC_W-1:0]];
    end
    if (cmd.issue_scheme) begin
      stage_kind_r <= KIND_SCHEME;
    end else if (cmd.issue_user) begin
      stage_kind_r <= KIND_USER;
    end else if (cmd.issue_status) begin
      stage_kind_r <= KIND_STATUS;
    end
    if (cmd.issue_status) begin
      stage_sts_r <= sts_code;
    end
    if (move) begin
      out_kind_r <= stage_kind_r;
      out_byte_r <= stage_byte;
      out_sts_r  <= (stage_kind_r == KIND_STATUS) ? stage_sts_r : STS_EMPTY;
      out_last_r <= (stage_kind_r == KIND_STATUS);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.kind        = out_kind_r;
  assign out_chan.out_byte    = out_byte_r;
  assign out_chan.status      = out_sts_r;
  assign out_chan.last_of_run = out_last_r;

endmodule
`default_nettype wire

// ----- hw/rtl/basic_auth_header_parser_top.sv -----
// flow: a header byte is taken in ST_ACCEPT; a byte that completes a base64 quad is followed
// by one decode step per decoded byte, through the single user store write port
// last item: closing quad decode plus tail check, then one result per cycle while out_chan is
// ready, none issued on the switch between scheme, user and status runs; results pass stage and output regs
// throughput: one header byte per cycle outside quad completions and the end-of-run flush
// reset: rst_n synchronous active low clears control state; the stores keep their contents
`default_nettype none
module basic_auth_header_parser_top #(
  parameter int SCHEME_MAX   = 16,
  parameter int USER_MAX     = 32,
  parameter int DECODE_EXTRA = 256
) (
  input  wire         clk,
  input  wire         rst_n,
  bahp_in_if.sink     in_chan,
  bahp_out_if.source  out_chan
);
  import bahp_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign in_chan.ready = in_ready;

  bahp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_is_last (in_chan.is_last),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bahp_dp #(
    .SCHEME_MAX   (SCHEME_MAX),
    .USER_MAX     (USER_MAX),
    .DECODE_EXTRA (DECODE_EXTRA)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_chan.data_byte),
    .in_byte_present (in_chan.byte_present),
    .cmd             (cmd),
    .stat            (stat),
    .out_chan        (out_chan)
  );

endmodule
`default_nettype wire
